// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/basr_pkg.sv =====
// ---------------------------------------------------------------------------
// basr_pkg
// Types and constants for the bridge converter serial reader.
// ---------------------------------------------------------------------------
package basr_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int TICK_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SAMPLE_W-1:0] OFFSET_FLIP = 24'h800000;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_HIGH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_READY_TMO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_HIGH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FINAL_HIGH  = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_RST_HI = 3'd1,
        PH_RST_LO = 3'd2,
        PH_WAIT   = 3'd3,
        PH_CLK_HI = 3'd4,
        PH_CLK_LO = 3'd5,
        PH_FIN_HI = 3'd6,
        PH_FIN_LO = 3'd7
    } phase_t;

    typedef struct packed {
        logic [9:0]  reset_high_ticks;
        logic [7:0]  reset_low_ticks;
        logic [15:0] ready_timeout;
        logic [7:0]  clock_high_ticks;
        logic [7:0]  final_high_ticks;
    } cfg_t;

endpackage

// ===== rtl/basr_if.sv =====
// ---------------------------------------------------------------------------
// basr_if
// Valid/ready channels: timing ticks in, pin/result words out, register writes.
// ---------------------------------------------------------------------------
interface basr_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic dout;

    modport source (output valid, output start_req, output dout, input ready);
    modport sink   (input valid, input start_req, input dout, output ready);
endinterface

interface basr_result_if;
    logic                          valid;
    logic                          ready;
    logic                          sck;
    logic                          busy_res;
    logic                          done_res;
    logic                          failed;
    logic [basr_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sck, output busy_res, output done_res,
                    output failed, output sample, input ready);
    modport sink   (input valid, input sck, input busy_res, input done_res,
                    input failed, input sample, output ready);
endinterface

interface basr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [basr_pkg::CFG_INDEX_W-1:0] index;
    logic [basr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/basr_regs.sv =====
// ---------------------------------------------------------------------------
// basr_regs
// Timing register bank, written through the configuration channel.
// ---------------------------------------------------------------------------
module basr_regs (
    input  logic           clk,
    input  logic           rst_n,
    basr_cfg_if.sink       cfg,
    output basr_pkg::cfg_t regs
);
    import basr_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.reset_high_ticks <= 10'd100;
            regs_reg.reset_low_ticks  <= 8'd2;
            regs_reg.ready_timeout    <= 16'd500;
            regs_reg.clock_high_ticks <= 8'd1;
            regs_reg.final_high_ticks <= 8'd2;
        end
        else if (cfg.valid)
        begin
            // unknown indexes are dropped
            case (cfg.index)
                REG_RESET_HIGH: regs_reg.reset_high_ticks <= cfg.data[9:0];
                REG_RESET_LOW:  regs_reg.reset_low_ticks  <= cfg.data[7:0];
                REG_READY_TMO:  regs_reg.ready_timeout    <= cfg.data;
                REG_CLOCK_HIGH: regs_reg.clock_high_ticks <= cfg.data[7:0];
                REG_FINAL_HIGH: regs_reg.final_high_ticks <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/bridge_adc_serial_reader.sv =====
// ---------------------------------------------------------------------------
// bridge_adc_serial_reader
// Two-wire bridge converter reader: pin sequencer with registered result.
// ---------------------------------------------------------------------------
// One tick word is taken every clock cycle unless the result is stalled, and
// each gives one result word (clock pin level, busy, done, failed, sample) in
// the next cycle from the result register. A start request while idle drives
// the clock pin high for reset_high_ticks, low for reset_low_ticks, then waits
// up to ready_timeout ticks for the data pin to go low (done with failed and
// sample 0 on timeout). DATA_BITS pulses of clock_high_ticks high and one low
// tick each shift the data pin in, MSB first; a final pulse of final_high_ticks
// high and one low tick end the read with the 24-bit sample XOR 0x800000. The
// timing registers aside, the sequencer state and the result register are the
// only stores, so the rate is set by the result register alone: a tick word is
// accepted when the result register is empty or being drained in that cycle.
module bridge_adc_serial_reader #(
    parameter int DATA_BITS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    basr_tick_if.sink     tick,
    basr_result_if.source result,
    basr_cfg_if.sink      cfg
);
    import basr_pkg::*;
`include "assert_macros.svh"

    localparam int                BIT_W    = $clog2(DATA_BITS);
    localparam logic [BIT_W-1:0]  LAST_BIT = BIT_W'(DATA_BITS - 1);

    cfg_t regs;

    basr_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [SAMPLE_W-1:0] shift_reg, shift_next;

    logic                out_valid_reg, out_valid_next;
    logic                sck_reg, busy_reg, done_reg, failed_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    phase_t              ph;
    logic [TICK_W-1:0]   tc, tc_inc, limit;
    logic                reached;
    logic                sck_c, busy_c, done_c, failed_c;
    logic [SAMPLE_W-1:0] sample_c;

    logic in_fire;
    logic out_fire;

    assign tick.ready = !out_valid_reg || result.ready;
    assign in_fire    = tick.valid && tick.ready;
    assign out_fire   = out_valid_reg && result.ready;

    // working phase for this tick: a start in idle begins on the same tick
    always_comb
    begin
        ph = phase_reg;
        tc = tick_reg;
        if (phase_reg == PH_IDLE && tick.start_req)
        begin
            ph = PH_RST_HI;
            tc = '0;
        end
        case (ph)
            PH_RST_HI: limit = TICK_W'(regs.reset_high_ticks);
            PH_RST_LO: limit = TICK_W'(regs.reset_low_ticks);
            PH_WAIT:   limit = regs.ready_timeout;
            PH_CLK_HI: limit = TICK_W'(regs.clock_high_ticks);
            PH_FIN_HI: limit = TICK_W'(regs.final_high_ticks);
            default:   limit = '0;
        endcase
        tc_inc  = tc + TICK_W'(1);
        // a limit of zero ends after one tick, as does one
        reached = (tc_inc >= limit);
    end

    // next state
    always_comb
    begin
        phase_next = ph;
        tick_next  = reached ? '0 : tc_inc;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        case (ph)
            PH_RST_HI: if (reached) phase_next = PH_RST_LO;
            PH_RST_LO: if (reached) phase_next = PH_WAIT;
            PH_WAIT:
            begin
                if (!tick.dout)
                begin
                    phase_next = PH_CLK_HI;
                    tick_next  = '0;
                    bit_next   = '0;
                    shift_next = '0;
                end
                else if (reached)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_CLK_HI: if (reached) phase_next = PH_CLK_LO;
            PH_CLK_LO:
            begin
                shift_next = {shift_reg[SAMPLE_W-2:0], tick.dout};
                tick_next  = '0;
                if (bit_reg == LAST_BIT)
                begin
                    bit_next   = '0;
                    phase_next = PH_FIN_HI;
                end
                else
                begin
                    bit_next   = bit_reg + BIT_W'(1);
                    phase_next = PH_CLK_HI;
                end
            end
            PH_FIN_HI: if (reached) phase_next = PH_FIN_LO;
            PH_FIN_LO:
            begin
                tick_next  = tc;
                phase_next = PH_IDLE;
            end
            default:
            begin
                tick_next = tc;
            end
        endcase
    end

    // pin and result levels for this tick
    always_comb
    begin
        sck_c    = 1'b0;
        busy_c   = 1'b1;
        done_c   = 1'b0;
        failed_c = 1'b0;
        sample_c = '0;
        case (ph)
            PH_RST_HI, PH_CLK_HI, PH_FIN_HI: sck_c = 1'b1;
            PH_RST_LO, PH_CLK_LO: ;
            PH_WAIT:
            begin
                if (tick.dout && reached)
                begin
                    done_c   = 1'b1;
                    failed_c = 1'b1;
                end
            end
            PH_FIN_LO:
            begin
                done_c   = 1'b1;
                sample_c = shift_reg ^ OFFSET_FLIP;
            end
            default: busy_c = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_fire)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sck_reg    <= sck_c;
            busy_reg   <= busy_c;
            done_reg   <= done_c;
            failed_reg <= failed_c;
            sample_reg <= sample_c;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.sck      = sck_reg;
    assign result.busy_res = busy_reg;
    assign result.done_res = done_reg;
    assign result.failed   = failed_reg;
    assign result.sample   = sample_reg;

    `ASSERT_IMPLY(a_done_busy, clk, rst_n, out_valid_reg && done_reg, busy_reg)
    `ASSERT_IMPLY(a_fail_done, clk, rst_n, out_valid_reg && failed_reg, done_reg && sample_reg == '0)
    `ASSERT_IMPLY(a_sample_done, clk, rst_n, out_valid_reg && !done_reg, sample_reg == '0)
    `ASSERT_IMPLY(a_idle_bits, clk, rst_n, phase_reg == PH_IDLE, bit_reg == '0)
    `ASSERT_NEXT(a_fire_valid, clk, rst_n, in_fire, out_valid_reg)

endmodule

// ===== tb/tb_bridge_adc_serial_reader.sv =====
// ---------------------------------------------------------------------------
// tb_bridge_adc_serial_reader
// Tick-level check of the bridge converter reader. Every accepted tick word
// is run through an in-bench model of the pin sequencer. The model gives the
// pin/result word that the block must return for that tick, and the words
// are compared in order. The run covers default, minimum and zero spans and
// the widest ready wait, then random register settings with mostly short,
// well-formed reads.
// ---------------------------------------------------------------------------
module tb_bridge_adc_serial_reader;
    timeunit 1ns;
    timeprecision 1ps;

    import basr_pkg::*;

    localparam int          DATA_BITS    = 24;
    localparam int          RANDOM_TICKS = 450;
    localparam longint      CYCLE_LIMIT  = 100_000;
    localparam int          LONG_HOLD    = 400;
    localparam int          SETTLE       = 4;
    localparam int          MAX_PRINTS   = 40;
    localparam int unsigned NEVER_READY  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                sck;
        logic                busy;
        logic                done;
        logic                failed;
        logic [SAMPLE_W-1:0] sample;
    } pin_word_t;

    class reading_scoreboard;
        cfg_t                regs;
        phase_t              phase;
        logic [TICK_W-1:0]   ticks;
        logic [4:0]          nbits;
        logic [SAMPLE_W-1:0] shreg;
        pin_word_t           pins_due[$];
        int                  errors;
        int                  words;

        function new();
            regs.reset_high_ticks = 10'd100;
            regs.reset_low_ticks  = 8'd2;
            regs.ready_timeout    = 16'd500;
            regs.clock_high_ticks = 8'd1;
            regs.final_high_ticks = 8'd2;
            phase  = PH_IDLE;
            ticks  = '0;
            nbits  = '0;
            shreg  = '0;
            errors = 0;
            words  = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RESET_HIGH: regs.reset_high_ticks = data[9:0];
                REG_RESET_LOW:  regs.reset_low_ticks  = data[7:0];
                REG_READY_TMO:  regs.ready_timeout    = data;
                REG_CLOCK_HIGH: regs.clock_high_ticks = data[7:0];
                REG_FINAL_HIGH: regs.final_high_ticks = data[7:0];
                default: ;
            endcase
        endfunction

        // one more tick of the current span; a span of zero ends after one tick
        function bit span_done(logic [TICK_W-1:0] span);
            ticks = ticks + 1'b1;
            if (ticks >= span)
            begin
                ticks = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_tick(logic start, logic dout);
            pin_word_t w;
            w      = '0;
            w.busy = 1'b1;
            if (phase == PH_IDLE && start)
            begin
                phase = PH_RST_HI;
                ticks = '0;
            end
            case (phase)
                PH_RST_HI:
                begin
                    w.sck = 1'b1;
                    if (span_done(TICK_W'(regs.reset_high_ticks)))
                        phase = PH_RST_LO;
                end
                PH_RST_LO:
                begin
                    if (span_done(TICK_W'(regs.reset_low_ticks)))
                        phase = PH_WAIT;
                end
                PH_WAIT:
                begin
                    if (!dout)
                    begin
                        phase = PH_CLK_HI;
                        ticks = '0;
                        nbits = '0;
                        shreg = '0;
                    end
                    else if (span_done(regs.ready_timeout))
                    begin
                        w.done   = 1'b1;
                        w.failed = 1'b1;
                        phase    = PH_IDLE;
                    end
                end
                PH_CLK_HI:
                begin
                    w.sck = 1'b1;
                    if (span_done(TICK_W'(regs.clock_high_ticks)))
                        phase = PH_CLK_LO;
                end
                PH_CLK_LO:
                begin
                    shreg = {shreg[SAMPLE_W-2:0], dout};
                    if (int'(nbits) + 1 >= DATA_BITS)
                    begin
                        nbits = '0;
                        phase = PH_FIN_HI;
                    end
                    else
                    begin
                        nbits = nbits + 1'b1;
                        phase = PH_CLK_HI;
                    end
                    ticks = '0;
                end
                PH_FIN_HI:
                begin
                    w.sck = 1'b1;
                    if (span_done(TICK_W'(regs.final_high_ticks)))
                        phase = PH_FIN_LO;
                end
                PH_FIN_LO:
                begin
                    w.done   = 1'b1;
                    w.sample = shreg ^ OFFSET_FLIP;
                    phase    = PH_IDLE;
                end
                default: w.busy = 1'b0;
            endcase
            pins_due.push_back(w);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch: %s", msg);
        endtask

        task check_pins(pin_word_t got);
            pin_word_t want;
            words++;
            if (pins_due.size() == 0)
            begin
                report_mismatch($sformatf("word %0d arrived with none due (%h)", words, got));
                return;
            end
            want = pins_due.pop_front();
            if (got.sck !== want.sck)
                report_mismatch($sformatf("word %0d sck %b want %b", words, got.sck, want.sck));
            if (got.busy !== want.busy)
                report_mismatch($sformatf("word %0d busy %b want %b", words, got.busy,
                                          want.busy));
            if (got.done !== want.done)
                report_mismatch($sformatf("word %0d done %b want %b", words, got.done,
                                          want.done));
            if (got.failed !== want.failed)
                report_mismatch($sformatf("word %0d failed %b want %b", words, got.failed,
                                          want.failed));
            if (got.sample !== want.sample)
                report_mismatch($sformatf("word %0d sample %h want %h", words, got.sample,
                                          want.sample));
        endtask

        function int pending();
            return pins_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    basr_tick_if   tk();
    basr_result_if rs();
    basr_cfg_if    cf();

    bridge_adc_serial_reader #(.DATA_BITS(DATA_BITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tk),
        .result (rs),
        .cfg    (cf)
    );

    reading_scoreboard sb = new;

    int unsigned ticks_sent = 0;
    bit          steady     = 1'b0;
    int          hold_asks  = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    int unsigned stall_left = 0;
    longint      cycles     = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly back to back, sometimes short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned pick_span(int unsigned top, int unsigned usual);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r < 3)
            return $urandom_range(1, top);
        return $urandom_range(1, usual);
    endfunction

    // random bits above the register width: the block must drop them
    function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned value, int width);
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] keep;
        if (width >= CFG_DATA_W)
            return CFG_DATA_W'(value);
        keep = (CFG_DATA_W'(1) << width) - 1'b1;
        junk = CFG_DATA_W'($urandom);
        return (junk & ~keep) | (CFG_DATA_W'(value) & keep);
    endfunction

    task automatic put_tick(logic start, logic dout);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            tk.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tk.valid     <= 1'b1;
        tk.start_req <= start;
        tk.dout      <= dout;
        @(posedge clk);
        while (!tk.ready) @(posedge clk);
        sb.note_tick(start, dout);
        ticks_sent++;
    endtask

    task automatic idle_ticks(int n);
        repeat (n) put_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    // one read from start until the model is idle again; the data pin follows
    // the converter unless noisy, and the ready wait lasts ready_delay ticks
    task automatic run_read(logic [SAMPLE_W-1:0] bits, int unsigned ready_delay, bit noisy,
                            bit poke);
        int unsigned waited;
        logic        d;
        waited = 0;
        put_tick(1'b1, 1'($urandom_range(0, 1)));
        while (sb.phase != PH_IDLE)
        begin
            case (sb.phase)
                PH_WAIT:
                begin
                    d = (waited < ready_delay);
                    waited++;
                end
                PH_CLK_LO: d = bits[DATA_BITS - 1 - int'(sb.nbits)];
                default:   d = 1'($urandom_range(0, 1));
            endcase
            if (noisy)
                d = 1'($urandom_range(0, 1));
            // a start while busy must be ignored
            put_tick(poke && $urandom_range(0, 15) == 0, d);
        end
    endtask

    task automatic send_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cf.valid <= 1'b1;
        cf.index <= idx;
        cf.data  <= data;
        @(posedge clk);
        while (!cf.ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_regs(int unsigned rh, int unsigned rl, int unsigned tmo,
                             int unsigned ch, int unsigned fh, bit stray);
        send_reg(REG_RESET_HIGH, with_junk(rh, 10));
        send_reg(REG_RESET_LOW,  with_junk(rl, 8));
        send_reg(REG_READY_TMO,  with_junk(tmo, 16));
        send_reg(REG_CLOCK_HIGH, with_junk(ch, 8));
        send_reg(REG_FINAL_HIGH, with_junk(fh, 8));
        // writes to unused indexes change nothing
        if (stray)
            for (int i = int'(REG_FINAL_HIGH) + 1; i < (1 << CFG_INDEX_W); i++)
                send_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
        cf.valid <= 1'b0;
    endtask

    // sender stops until every word has come back, then waits out the SETTLE quiet time
    task automatic settle();
        tk.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rs.ready <= 1'b0;
        else
        begin
            if (rs.valid && rs.ready)
                sb.check_pins(pin_word_t'({rs.sck, rs.busy_res, rs.done_res, rs.failed,
                                           rs.sample}));
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rs.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rs.ready <= 1'b0;
            end
            else
            begin
                rs.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_from;
        int unsigned rh, rl, tmo, ch, fh;
        int unsigned r;
        int          reads;
        bit          first;

        rst_n        <= 1'b0;
        tk.valid     <= 1'b0;
        tk.start_req <= 1'b0;
        tk.dout      <= 1'b0;
        cf.valid     <= 1'b0;
        cf.index     <= '0;
        cf.data      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers as they come out of reset
        run_read(24'h5A3C96, 3, 1'b0, 1'b1);
        idle_ticks(4);

        settle();
        load_regs(1, 1, 1, 1, 1, 1'b0);
        run_read(24'hFFFFFF, 0, 1'b0, 1'b0);
        run_read(24'h000001, 1, 1'b0, 1'b1);
        run_read(24'h000000, NEVER_READY, 1'b0, 1'b0);
        run_read(SAMPLE_W'($urandom), 0, 1'b1, 1'b0);

        // zero spans behave as one tick
        settle();
        load_regs(0, 0, 0, 0, 0, 1'b1);
        run_read(24'hA5A5A5, 0, 1'b0, 1'b0);
        run_read(24'h000000, NEVER_READY, 1'b0, 1'b0);
        run_read(24'h800000, 2, 1'b0, 1'b1);

        // widest ready wait, no idling
        settle();
        steady <= 1'b1;
        load_regs(2, 2, 65535, 2, 2, 1'b0);
        run_read(SAMPLE_W'($urandom), 9, 1'b0, 1'b0);
        settle();

        random_from = ticks_sent;
        first       = 1'b1;
        while (ticks_sent - random_from < RANDOM_TICKS)
        begin
            rh  = pick_span(40, 5);
            rl  = pick_span(20, 4);
            tmo = pick_span(60, 16);
            ch  = pick_span(4, 3);
            fh  = pick_span(20, 4);
            settle();
            steady <= ($urandom_range(0, 4) == 0) && !first;
            load_regs(rh, rl, tmo, ch, fh, $urandom_range(0, 3) == 0);
            // receiver holds off long enough for the tick input to back up
            if (first)
                hold_asks <= hold_asks + 1;
            first = 1'b0;
            reads = $urandom_range(2, 5);
            repeat (reads)
            begin
                if ($urandom_range(0, 5) == 0)
                    idle_ticks($urandom_range(1, 6));
                r = $urandom_range(0, 99);
                if (r < 12)
                    run_read(SAMPLE_W'($urandom), 0, 1'b1, 1'b1);
                else if (r < 22)
                    run_read(SAMPLE_W'($urandom), NEVER_READY, 1'b0, 1'b0);
                else
                    run_read(r < 30 ? 24'hFFFFFF : r < 38 ? 24'h000000 : SAMPLE_W'($urandom),
                             $urandom_range(0, tmo + tmo / 4), 1'b0,
                             $urandom_range(0, 3) == 0);
            end
        end

        settle();
        repeat (4 * SETTLE) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d words never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
